### sv/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg: shared definitions for the contiguous fit allocator
// Fit mode codes, item op codes, register indexes and the cell control bundle.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;
  localparam logic [1:0] MODE_NEXT  = 2'd3;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic REG_FIT_MODE      = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  localparam int SLOT_W   = 4;
  localparam int AMOUNT_W = 16;
  localparam int OWNER_W  = 5;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic [1:0] mode;
    logic       load_we;
    logic       grant_we;
  } cfa_ctl_t;

endpackage

### sv/contiguous_fit_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_fit_allocator: hole table with first, best, worst and next fit
// Keeps NUM_HOLES holes in a chain of cells and grants allocation requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry op, slot, amount and requester. A load beat (op 0)
//   writes a hole's size and marks it free; its result beat is presented the
//   cycle after acceptance. A request beat (op 1) searches the first
//   blocks_in_use holes for a free hole of at least amount bytes.
//   A request starts, then folds the next fit rover into the searched range
//   (rover mod n by repeated subtraction, one subtract per cycle), lets the
//   candidate ripple down the cell chain (one cell per cycle) and commits.
//   Each item yields one result beat. Only one item is in flight; the next
//   input beat is taken once the result register is free or being drained.
//   When the receiver stalls, the result beat holds and the sequencer waits
//   with the table untouched.
//   Reset clears every hole to size 0, free, owner 0, the rover to 0,
//   fit_mode to first fit and blocks_in_use to 16. Registers are written
//   through the APB port: fit_mode at 0x0, blocks_in_use at 0x4.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator #(
  parameter int NUM_HOLES = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [cfa_pkg::SLOT_W-1:0]     in_slot,
  input  logic [cfa_pkg::AMOUNT_W-1:0]   in_amount,
  input  logic [cfa_pkg::OWNER_W-1:0]    in_requester,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_granted,
  output logic [cfa_pkg::SLOT_W-1:0]     out_chosen_slot,
  output logic [cfa_pkg::AMOUNT_W-1:0]   out_leftover,
  // configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [2:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import cfa_pkg::*;

  localparam int IW = (NUM_HOLES > 1) ? $clog2(NUM_HOLES) : 1;
  localparam int CW = $clog2(NUM_HOLES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [1:0]           fit_mode_r;
  logic [4:0]           blocks_r;
  logic [IW-1:0]        rover_r;
  logic [IW-1:0]        start_r, start_nxt;
  logic [IW-1:0]        cnt_r, cnt_nxt;
  logic [SIZE_BITS-1:0] amt_r;
  logic [OWNER_W-1:0]   req_r;
  logic                 out_valid_r;
  logic                 out_granted_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [AMOUNT_W-1:0]  out_left_r;

  logic                 in_acc;
  logic                 out_free;
  logic                 cfg_we;
  logic [CW-1:0]        n_eff;
  logic [SIZE_BITS-1:0] in_amt;
  logic [SIZE_BITS-1:0] cell_amt;
  logic                 slot_ok;
  logic                 commit;
  cfa_ctl_t             ctl;

  logic                 found_w [NUM_HOLES+1];
  logic [IW-1:0]        pick_w  [NUM_HOLES+1];
  logic [SIZE_BITS-1:0] rem_w   [NUM_HOLES+1];
  logic                 wrap_w  [NUM_HOLES+1];

  // ---- configuration port -------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= MODE_FIRST;
      blocks_r   <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_paddr[2])
        REG_FIT_MODE:      fit_mode_r <= cfg_pwdata[1:0];
        REG_BLOCKS_IN_USE: blocks_r   <= cfg_pwdata[4:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_FIT_MODE:      cfg_prdata = {30'd0, fit_mode_r};
      REG_BLOCKS_IN_USE: cfg_prdata = {27'd0, blocks_r};
      default:           cfg_prdata = '0;
    endcase
  end

  // Saturate the searched count to the table size.
  always_comb begin
    if ({4'd0, blocks_r} > 9'(NUM_HOLES)) begin
      n_eff = CW'(NUM_HOLES);
    end else begin
      n_eff = CW'(blocks_r);
    end
  end

  // ---- handshake ----------------------------------------------------------
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;
  assign in_amt   = SIZE_BITS'(in_amount);
  assign slot_ok  = {5'd0, in_slot} < 9'(NUM_HOLES);
  assign commit   = (state_r == ST_DONE) && out_free;

  // ---- sequencer ----------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    start_nxt = start_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_op == OP_REQUEST) begin
          state_nxt = ST_MOD;
          start_nxt = rover_r;
        end
      end
      ST_MOD: begin
        // Fold the rover into the searched range, one subtract per cycle.
        if (n_eff != '0 && CW'(start_r) >= n_eff) begin
          start_nxt = start_r - IW'(n_eff);
        end else begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        // The candidate settles at the chain end after one pass per cell.
        if (cnt_r == IW'(NUM_HOLES - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rover_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit && found_w[NUM_HOLES] && fit_mode_r == MODE_NEXT) begin
        rover_r <= pick_w[NUM_HOLES];
      end
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    cnt_r   <= cnt_nxt;
    if (in_acc) begin
      amt_r <= in_amt;
      req_r <= in_requester;
    end
  end

  // ---- result register ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_op == OP_LOAD) begin
      out_valid_r <= 1'b1;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_LOAD) begin
      out_granted_r <= slot_ok;
      out_slot_r    <= in_slot;
      out_left_r    <= slot_ok ? AMOUNT_W'(in_amt) : '0;
    end else if (commit) begin
      out_granted_r <= found_w[NUM_HOLES];
      out_slot_r    <= found_w[NUM_HOLES] ? SLOT_W'(pick_w[NUM_HOLES]) : '0;
      out_left_r    <= found_w[NUM_HOLES] ? AMOUNT_W'(rem_w[NUM_HOLES]) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_granted     = out_granted_r;
  assign out_chosen_slot = out_slot_r;
  assign out_leftover    = out_left_r;

  // ---- cell chain ---------------------------------------------------------
  assign ctl.mode     = fit_mode_r;
  assign ctl.load_we  = in_acc && in_op == OP_LOAD;
  assign ctl.grant_we = commit && found_w[NUM_HOLES];
  assign cell_amt     = (state_r == ST_IDLE) ? in_amt : amt_r;

  // Seed the chain with an empty candidate.
  assign found_w[0] = 1'b0;
  assign pick_w[0]  = '0;
  assign rem_w[0]   = '0;
  assign wrap_w[0]  = 1'b0;

  for (genvar k = 0; k < NUM_HOLES; k++) begin : g_cell
    logic sel;

    // Load addresses by slot, grant by the winning index.
    assign sel = (state_r == ST_IDLE) ? ({5'd0, in_slot} == 9'(k))
                                      : (pick_w[NUM_HOLES] == IW'(k));

    cfa_cell #(
      .NUM_HOLES (NUM_HOLES),
      .SIZE_BITS (SIZE_BITS),
      .IDX       (k),
      .IW        (IW),
      .CW        (CW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .sel          (sel),
      .amt          (cell_amt),
      .owner        (req_r),
      .n_eff        (n_eff),
      .start        (start_r),
      .cand_found_i (found_w[k]),
      .cand_pick_i  (pick_w[k]),
      .cand_rem_i   (rem_w[k]),
      .cand_wrap_i  (wrap_w[k]),
      .cand_found_r (found_w[k+1]),
      .cand_pick_r  (pick_w[k+1]),
      .cand_rem_r   (rem_w[k+1]),
      .cand_wrap_r  (wrap_w[k+1])
    );
  end

endmodule

### sv/cfa_cell.sv
// ----------------------------------------------------------------------------
// cfa_cell: one hole of the allocator chain
// Holds a hole's size, free mark and owner; folds its hole into the search
// candidate that arrives from the left neighbor and registers it onward.
// ----------------------------------------------------------------------------
module cfa_cell #(
  parameter int NUM_HOLES = 16,
  parameter int SIZE_BITS = 16,
  parameter int IDX       = 0,
  parameter int IW        = (NUM_HOLES > 1) ? $clog2(NUM_HOLES) : 1,
  parameter int CW        = $clog2(NUM_HOLES + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfa_pkg::cfa_ctl_t        ctl,
  input  logic                     sel,
  input  logic [SIZE_BITS-1:0]     amt,
  input  logic [cfa_pkg::OWNER_W-1:0] owner,
  input  logic [CW-1:0]            n_eff,
  input  logic [IW-1:0]            start,
  input  logic                     cand_found_i,
  input  logic [IW-1:0]            cand_pick_i,
  input  logic [SIZE_BITS-1:0]     cand_rem_i,
  input  logic                     cand_wrap_i,
  output logic                     cand_found_r,
  output logic [IW-1:0]            cand_pick_r,
  output logic [SIZE_BITS-1:0]     cand_rem_r,
  output logic                     cand_wrap_r
);
  import cfa_pkg::*;

  localparam logic [CW-1:0] IDX_N = CW'(IDX);
  localparam logic [IW-1:0] IDX_P = IW'(IDX);

  logic [SIZE_BITS-1:0] size_r;
  logic                 free_r;
  logic [OWNER_W-1:0]   owner_r;

  logic [SIZE_BITS-1:0] rem;
  logic                 fits;
  logic                 wrap;
  logic                 wins;

  assign rem  = size_r - amt;
  assign fits = (IDX_N < n_eff) && free_r && (size_r >= amt);
  assign wrap = IDX_P < start;

  always_comb begin
    case (ctl.mode)
      MODE_BEST:  wins = !cand_found_i || (rem < cand_rem_i);
      MODE_WORST: wins = !cand_found_i || (rem > cand_rem_i);
      MODE_NEXT:  wins = !cand_found_i || (cand_wrap_i && !wrap);
      default:    wins = !cand_found_i;
    endcase
  end

  // Hole state: load writes a fresh free hole, grant shrinks and claims it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= '0;
      free_r  <= 1'b1;
      owner_r <= '0;
    end else if (sel && ctl.load_we) begin
      size_r  <= amt;
      free_r  <= 1'b1;
      owner_r <= '0;
    end else if (sel && ctl.grant_we) begin
      size_r  <= rem;
      free_r  <= 1'b0;
      owner_r <= owner;
    end
  end

  // Candidate stage: take this hole over the incoming one when it wins.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_found_r <= 1'b0;
    end else begin
      cand_found_r <= cand_found_i || fits;
    end
  end

  always_ff @(posedge clk) begin
    if (fits && wins) begin
      cand_pick_r <= IDX_P;
      cand_rem_r  <= rem;
      cand_wrap_r <= wrap;
    end else begin
      cand_pick_r <= cand_pick_i;
      cand_rem_r  <= cand_rem_i;
      cand_wrap_r <= cand_wrap_i;
    end
  end

endmodule

### sim/fit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fit_checker: scoreboard for the contiguous fit allocator
// Watches the input, result and register channels, keeps its own copy of the
// hole table and the register settings, and compares every result beat
// field by field with the oldest predicted grant.
// ----------------------------------------------------------------------------
module fit_checker
  import cfa_pkg::*;
#(
  parameter int NUM_HOLES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_op,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic [AMOUNT_W-1:0] in_amount,
  input  logic [OWNER_W-1:0]  in_requester,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                out_granted,
  input  logic [SLOT_W-1:0]   out_chosen_slot,
  input  logic [AMOUNT_W-1:0] out_leftover,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  input  logic [31:0]         cfg_prdata,
  input  logic                cfg_pready,
  output int                  pending_grants,
  output int                  fail_count
);

  localparam logic [2:0] ADDR_FIT_MODE      = {REG_FIT_MODE, 2'b00};
  localparam logic [2:0] ADDR_BLOCKS_IN_USE = {REG_BLOCKS_IN_USE, 2'b00};

  typedef struct packed {
    logic                granted;
    logic [SLOT_W-1:0]   slot;
    logic [AMOUNT_W-1:0] leftover;
  } grant_t;

  logic [AMOUNT_W-1:0] hole_size  [NUM_HOLES];
  logic                hole_free  [NUM_HOLES];
  logic [OWNER_W-1:0]  hole_owner [NUM_HOLES];
  logic [SLOT_W-1:0]   rover;
  logic [1:0]          fit_mode;
  logic [4:0]          blocks_in_use;

  grant_t expected_grants[$];
  int     errors = 0;

  // Apply one input beat to the shadow table and return the grant it causes.
  function automatic grant_t serve_item(logic op, logic [SLOT_W-1:0] slot,
                                        logic [AMOUNT_W-1:0] amount,
                                        logic [OWNER_W-1:0] requester);
    grant_t              res;
    int                  n;
    int                  k;
    int                  idx;
    int                  pick;
    bit                  found;
    logic [AMOUNT_W-1:0] rem;
    logic [AMOUNT_W-1:0] best;
    res   = '0;
    found = 1'b0;
    pick  = 0;
    best  = '0;
    if (op == OP_LOAD) begin
      hole_size[slot]  = amount;
      hole_free[slot]  = 1'b1;
      hole_owner[slot] = '0;
      res.granted  = 1'b1;
      res.slot     = slot;
      res.leftover = amount;
      return res;
    end
    n = (blocks_in_use > NUM_HOLES) ? NUM_HOLES : int'(blocks_in_use);
    if (fit_mode == MODE_NEXT) begin
      for (k = 0; k < n && !found; k++) begin
        idx = (int'(rover) + k) % n;
        if (hole_free[idx] && hole_size[idx] >= amount) begin
          found = 1'b1;
          pick  = idx;
        end
      end
      if (found) rover = pick[SLOT_W-1:0];
    end else begin
      for (k = 0; k < n && !(found && fit_mode == MODE_FIRST); k++) begin
        if (hole_free[k] && hole_size[k] >= amount) begin
          rem = hole_size[k] - amount;
          if (!found || (fit_mode == MODE_BEST && rem < best) ||
              (fit_mode == MODE_WORST && rem > best)) begin
            found = 1'b1;
            pick  = k;
            best  = rem;
          end
        end
      end
    end
    if (found) begin
      hole_size[pick]  = hole_size[pick] - amount;
      hole_free[pick]  = 1'b0;
      hole_owner[pick] = requester;
      res.granted  = 1'b1;
      res.slot     = pick[SLOT_W-1:0];
      res.leftover = hole_size[pick];
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    grant_t exp_grant;
    logic [31:0] exp_rd;
    if (!rst_n) begin
      for (int h = 0; h < NUM_HOLES; h++) begin
        hole_size[h]  = '0;
        hole_free[h]  = 1'b1;
        hole_owner[h] = '0;
      end
      rover         = '0;
      fit_mode      = MODE_FIRST;
      blocks_in_use = 5'd16;
      expected_grants.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          $error("result beat with no grant pending");
          errors++;
        end else begin
          exp_grant = expected_grants.pop_front();
          if (out_granted !== exp_grant.granted) begin
            $error("granted: expected %0d, actual %0d", exp_grant.granted, out_granted);
            errors++;
          end
          if (out_chosen_slot !== exp_grant.slot) begin
            $error("chosen_slot: expected %0d, actual %0d", exp_grant.slot,
                   out_chosen_slot);
            errors++;
          end
          if (out_leftover !== exp_grant.leftover) begin
            $error("leftover: expected %0d, actual %0d", exp_grant.leftover, out_leftover);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_grants.push_back(serve_item(in_op, in_slot, in_amount, in_requester));
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr == ADDR_FIT_MODE) fit_mode = cfg_pwdata[1:0];
          else if (cfg_paddr == ADDR_BLOCKS_IN_USE) blocks_in_use = cfg_pwdata[4:0];
        end else begin
          exp_rd = (cfg_paddr == ADDR_FIT_MODE) ? {30'd0, fit_mode} : {27'd0, blocks_in_use};
          if (cfg_prdata !== exp_rd) begin
            $error("prdata: expected %0d, actual %0d", exp_rd, cfg_prdata);
            errors++;
          end
        end
      end
    end
    pending_grants <= expected_grants.size();
    fail_count     <= errors;
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the contiguous fit allocator
// Loads holes and issues allocation requests under every fit mode and a range
// of searched table sizes, with random gaps on both channels. A separate
// checker predicts each grant and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
  import cfa_pkg::*;

  localparam int MAX_IDLE     = 12;
  // Worst request: up to 15 rover folding steps plus the scan of every cell; give margin.
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 3000;
  localparam int RAND_PHASES  = 17;
  localparam int PHASE_ITEMS  = 50;

  localparam logic [2:0] ADDR_FIT_MODE      = {REG_FIT_MODE, 2'b00};
  localparam logic [2:0] ADDR_BLOCKS_IN_USE = {REG_BLOCKS_IN_USE, 2'b00};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_op = OP_LOAD;
  logic [SLOT_W-1:0]   in_slot = '0;
  logic [AMOUNT_W-1:0] in_amount = '0;
  logic [OWNER_W-1:0]  in_requester = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_granted;
  logic [SLOT_W-1:0]   out_chosen_slot;
  logic [AMOUNT_W-1:0] out_leftover;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [2:0]          cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  int pending_grants;
  int fail_count;
  int quiet_cycles = 0;
  // Cleared for stretches in which both sides run without gaps.
  bit idle_on = 1'b1;

  contiguous_fit_allocator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_slot         (in_slot),
    .in_amount       (in_amount),
    .in_requester    (in_requester),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_granted     (out_granted),
    .out_chosen_slot (out_chosen_slot),
    .out_leftover    (out_leftover),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  fit_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_slot         (in_slot),
    .in_amount       (in_amount),
    .in_requester    (in_requester),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_granted     (out_granted),
    .out_chosen_slot (out_chosen_slot),
    .out_leftover    (out_leftover),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready),
    .pending_grants  (pending_grants),
    .fail_count      (fail_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: end the run if no beat of any kind moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: draw a stall before each beat; keep ready high when the
  // draw is zero so it never drops and rises in the same step.
  initial begin : result_sink
    int stall;
    forever begin
      stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Send one input beat after a random gap; return at the accepting edge.
  task automatic send_beat(logic op, logic [SLOT_W-1:0] slot,
                           logic [AMOUNT_W-1:0] amount, logic [OWNER_W-1:0] requester);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_slot      <= slot;
    in_amount    <= amount;
    in_requester <= requester;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // One APB transfer: setup, access, then idle with psel low, so the
  // next transfer never raises psel in the step that lowers it.
  task automatic apb_access(logic write, logic [2:0] addr, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the block, then write both registers and read them back.
  task automatic apply_setting(logic [1:0] mode, logic [4:0] blocks);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_grants != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    apb_access(1'b1, ADDR_FIT_MODE, {30'd0, mode});
    apb_access(1'b1, ADDR_BLOCKS_IN_USE, {27'd0, blocks});
    apb_access(1'b0, ADDR_FIT_MODE, 32'd0);
    apb_access(1'b0, ADDR_BLOCKS_IN_USE, 32'd0);
  endtask

  // Random workload: loads keep refilling the table so requests keep finding
  // holes; occasional huge or zero amounts act as noise.
  task automatic random_workload(int count);
    logic [AMOUNT_W-1:0] amt;
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < 40) begin
        case (pick)
          0:       amt = '0;
          1:       amt = '1;
          2, 3:    amt = AMOUNT_W'($urandom);
          default: amt = AMOUNT_W'($urandom_range(0, 1000));
        endcase
        send_beat(OP_LOAD, SLOT_W'($urandom), amt, OWNER_W'($urandom));
      end else begin
        case (pick)
          0:       amt = '0;
          1:       amt = AMOUNT_W'($urandom);
          2:       amt = '1;
          default: amt = AMOUNT_W'($urandom_range(1, 300));
        endcase
        send_beat(OP_REQUEST, SLOT_W'($urandom), amt, OWNER_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int sel;
    logic [4:0] blocks;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero amount against the all-zero table grants hole 0.
    apply_setting(MODE_FIRST, 5'd16);
    send_beat(OP_REQUEST, 4'd9, 16'd0, 5'd31);
    send_beat(OP_LOAD, 4'd15, 16'hFFFF, 5'd0);
    send_beat(OP_LOAD, 4'd3, 16'd500, 5'd31);
    send_beat(OP_LOAD, 4'd8, 16'd200, 5'd0);
    send_beat(OP_REQUEST, 4'd0, 16'hFFFF, 5'd1);
    // Largest amount request again: must be refused.
    send_beat(OP_REQUEST, 4'd15, 16'hFFFF, 5'd2);
    send_beat(OP_LOAD, 4'd0, 16'd0, 5'd31);

    apply_setting(MODE_BEST, 5'd16);
    send_beat(OP_REQUEST, 4'd0, 16'd150, 5'd2);
    send_beat(OP_REQUEST, 4'd0, 16'd100, 5'd3);

    // Worst fit with two equal holes: lowest index wins the tie.
    apply_setting(MODE_WORST, 5'd16);
    send_beat(OP_LOAD, 4'd10, 16'd1000, 5'd0);
    send_beat(OP_LOAD, 4'd12, 16'd1000, 5'd0);
    send_beat(OP_REQUEST, 4'd0, 16'd10, 5'd4);

    apply_setting(MODE_NEXT, 5'd16);
    send_beat(OP_REQUEST, 4'd0, 16'd1, 5'd5);
    send_beat(OP_REQUEST, 4'd0, 16'd1, 5'd6);
    // Shrink the searched range below the rover: scan wraps from rover mod n.
    apply_setting(MODE_NEXT, 5'd5);
    send_beat(OP_LOAD, 4'd4, 16'd7, 5'd0);
    send_beat(OP_REQUEST, 4'd0, 16'd7, 5'd7);

    // Empty searched range refuses everything; oversized range saturates.
    apply_setting(MODE_FIRST, 5'd0);
    send_beat(OP_REQUEST, 4'd0, 16'd0, 5'd8);
    apply_setting(MODE_BEST, 5'd31);
    send_beat(OP_REQUEST, 4'd0, 16'd0, 5'd9);
    apply_setting(MODE_FIRST, 5'd1);
    send_beat(OP_LOAD, 4'd0, 16'd50, 5'd0);
    send_beat(OP_REQUEST, 4'd0, 16'd50, 5'd31);
    send_beat(OP_REQUEST, 4'd0, 16'd0, 5'd10);

    // Random phases: fresh setting each time, mostly in the legal range.
    repeat (RAND_PHASES) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       blocks = 5'd0;
        1:       blocks = 5'($urandom_range(17, 31));
        2:       blocks = 5'd16;
        default: blocks = 5'($urandom_range(1, 16));
      endcase
      apply_setting(2'($urandom_range(0, 3)), blocks);
      idle_on <= ($urandom_range(0, 3) != 0);
      random_workload(PHASE_ITEMS);
    end

    // Drain: hold until every grant has come back, then let the block settle.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_grants != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_grants == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
sv/cfa_pkg.sv
sv/cfa_cell.sv
sv/contiguous_fit_allocator.sv
sim/fit_checker.sv
sim/testbench.sv
